// ----- rtl/epa_pkg.sv -----
package epa_pkg;

  localparam int HASH_BITS_DEF        = 8;
  localparam int PROGRAM_WAYS_DEF     = 4;
  localparam int LIBS_PER_PROGRAM_DEF = 16;

  // golden-ratio multiplier, split in 32-bit halves
  localparam logic [31:0] GOLDEN_LO = 32'h80B583EB;
  localparam logic [31:0] GOLDEN_HI = 32'h61C88646;

  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] MODE_TRAIN = 2'd0;
  localparam logic [1:0] MODE_ALERT = 2'd1;

  localparam logic [1:0] INS_NONE    = 2'd0;
  localparam logic [1:0] INS_STORED  = 2'd1;
  localparam logic [1:0] INS_PRESENT = 2'd2;
  localparam logic [1:0] INS_DROPPED = 2'd3;

endpackage

// ----- rtl/epa_ram.sv -----
module epa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/epa_hash.sv -----
module epa_hash
  import epa_pkg::*;
#(
  parameter int HASH_BITS = HASH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          dev,
  input  logic [63:0]          ino,
  output logic                 done,
  output logic [HASH_BITS-1:0] bucket
);

  // low 64 bits of key * golden over three 32x32 products
  logic [2:0]  step_r, step_nxt;
  logic [31:0] kh_r, kl_r;
  logic [63:0] p0_r;
  logic [31:0] acc_r;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [31:0] top;
  logic        done_r;
  logic [HASH_BITS-1:0] bucket_r;

  always_comb begin
    case (step_r)
      3'd2: begin ma = kh_r; mb = GOLDEN_LO; end
      3'd3: begin ma = kl_r; mb = GOLDEN_HI; end
      default: begin ma = kl_r; mb = GOLDEN_LO; end
    endcase
    prod = ma * mb;
    top  = p0_r[63:32] + acc_r;
    step_nxt = step_r;
    if (start) begin
      step_nxt = 3'd1;
    end else if (step_r != 3'd0) begin
      step_nxt = (step_r == 3'd4) ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= (step_r == 3'd4);
    end
    if (start) begin
      kh_r <= dev | ino[63:32];
      kl_r <= ino[31:0];
    end
    case (step_r)
      3'd1: p0_r <= prod;
      3'd2: acc_r <= prod[31:0];
      3'd3: acc_r <= acc_r + prod[31:0];
      3'd4: bucket_r <= top[31:32-HASH_BITS];
      default: ;
    endcase
  end

  assign done   = done_r;
  assign bucket = bucket_r;

endmodule

// ----- rtl/exec_pair_allowlist.sv -----
// Check: hash, valid-row read, program-way probes, then a binary search of the library list;
//   an insert adds a sorted shift, a read and a write state per library moved (single-port table RAMs).
// Throughput: one word at a time; the next word is taken once the result is registered.
// Clear: a sweep writes one bucket row of valid bits per cycle, then returns a result word.
// Reset: mode goes to training, then a sweep over all 2^HASH_BITS rows clears the valid
//   RAM; no input word is accepted during the sweep.
module exec_pair_allowlist
  import epa_pkg::*;
#(
  parameter int HASH_BITS        = HASH_BITS_DEF,
  parameter int PROGRAM_WAYS     = PROGRAM_WAYS_DEF,
  parameter int LIBS_PER_PROGRAM = LIBS_PER_PROGRAM_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_wr_data,    // mode
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,       // exe_dev, exe_ino, lib_dev, lib_ino
  input  logic [1:0]   in_tuser,       // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata       // verdict, alert, pair_found, insert_status, pad
);

  localparam int WW = (PROGRAM_WAYS > 1) ? $clog2(PROGRAM_WAYS) : 1;
  localparam int LW = (LIBS_PER_PROGRAM > 1) ? $clog2(LIBS_PER_PROGRAM) : 1;
  localparam int CW = $clog2(LIBS_PER_PROGRAM + 1);
  localparam int SW = HASH_BITS + WW;
  localparam int ROWS = 1 << HASH_BITS;
  localparam int PROG_DEPTH = 1 << SW;
  localparam int LIB_DEPTH = 1 << (SW + LW);
  localparam int PW = 96 + CW;

  localparam logic [3:0] S_IDLE = 4'd0, S_SWEEP = 4'd1, S_HASH = 4'd2, S_VRD = 4'd3,
                         S_VWT = 4'd4, S_PRD = 4'd5, S_PCMP = 4'd6, S_SRCH = 4'd7,
                         S_SCMP = 4'd8, S_DECIDE = 4'd9, S_SHRD = 4'd10,
                         S_SHWR = 4'd11, S_FIN = 4'd12, S_DONE = 4'd13;

  logic [3:0]   state_r;
  logic [1:0]   mode_r;
  logic [1:0]   op_r;
  logic [31:0]  ed_r, ld_r;
  logic [63:0]  ei_r, li_r;
  logic [HASH_BITS-1:0] sweep_r;
  logic         rep_r;
  logic [HASH_BITS-1:0] bucket_r;
  logic [PROGRAM_WAYS-1:0] vrow_r;
  logic [WW-1:0] way_r;
  logic [CW-1:0] cnt_r, lo_r, hi_r, mid_r, k_r;
  logic         hit_r;
  logic [4:0]   res_r;
  logic         out_valid_r;
  logic [4:0]   out_res_r;

  logic         hash_start, hash_done;
  logic [HASH_BITS-1:0] hash_bucket;

  logic         v_we;
  logic [HASH_BITS-1:0] v_addr;
  logic [PROGRAM_WAYS-1:0] v_wdata, v_rdata;
  logic         p_we;
  logic [SW-1:0] p_addr;
  logic [PW-1:0] p_wdata, p_rdata;
  logic         l_we;
  logic [SW+LW-1:0] l_addr;
  logic [95:0]  l_wdata, l_rdata;

  logic         ins;
  logic         enforce;
  logic         in_acc;
  logic [WW-1:0] free_way;
  logic         row_full;
  logic         pmatch;
  logic [CW:0]  mid_sum;
  logic [CW-1:0] mid;
  logic [SW-1:0] slot;
  logic [CW-1:0] km1;

  assign ins     = (op_r == OP_LOAD) || (mode_r == MODE_TRAIN);
  assign enforce = (mode_r != MODE_TRAIN) && (mode_r != MODE_ALERT);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc  = in_tvalid && in_tready;
  assign row_full = &vrow_r;
  assign pmatch  = vrow_r[way_r] && (p_rdata[PW-1:PW-32] == ed_r) &&
                   (p_rdata[PW-33:CW] == ei_r);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CW:1];
  assign slot    = {bucket_r, way_r};
  assign km1     = k_r - CW'(1);

  always_comb begin
    free_way = '0;
    for (int j = PROGRAM_WAYS - 1; j >= 0; j--) begin
      if (!vrow_r[j]) free_way = WW'(j);
    end
  end

  always_comb begin
    hash_start = in_acc && ((in_tuser == OP_EVENT) || (in_tuser == OP_LOAD));
    v_we = 1'b0; v_addr = bucket_r; v_wdata = vrow_r;
    p_we = 1'b0; p_addr = slot; p_wdata = {ed_r, ei_r, cnt_r + CW'(1)};
    l_we = 1'b0; l_addr = {slot, mid[LW-1:0]}; l_wdata = {ld_r, li_r};
    case (state_r)
      S_SWEEP: begin v_we = 1'b1; v_addr = sweep_r; v_wdata = '0; end
      S_PCMP: begin
        v_wdata = vrow_r | (PROGRAM_WAYS'(1) << free_way);
        v_we = !pmatch && (way_r == WW'(PROGRAM_WAYS - 1)) && ins && !row_full;
      end
      S_SHRD: begin
        if (k_r > lo_r) begin
          l_addr = {slot, km1[LW-1:0]};
        end else begin
          l_we = 1'b1; l_addr = {slot, lo_r[LW-1:0]};
        end
      end
      S_SHWR: begin l_we = 1'b1; l_addr = {slot, k_r[LW-1:0]}; l_wdata = l_rdata; end
      S_FIN: p_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      mode_r <= MODE_TRAIN;
      sweep_r <= '0;
      rep_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_r <= '0;
            if (in_tuser == OP_CLEAR) begin
              state_r <= S_SWEEP; sweep_r <= '0; rep_r <= 1'b1;
            end else if (hash_start) begin
              state_r <= S_HASH;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SWEEP: begin
          sweep_r <= sweep_r + HASH_BITS'(1);
          if (&sweep_r) state_r <= rep_r ? S_DONE : S_IDLE;
        end
        S_HASH: if (hash_done) state_r <= S_VRD;
        S_VRD: state_r <= S_VWT;
        S_VWT: state_r <= S_PRD;
        S_PRD: state_r <= S_PCMP;
        S_PCMP: begin
          if (pmatch) begin
            cnt_r <= p_rdata[CW-1:0]; lo_r <= '0; hi_r <= p_rdata[CW-1:0];
            hit_r <= 1'b0; state_r <= S_SRCH;
          end else if (way_r == WW'(PROGRAM_WAYS - 1)) begin
            if (!ins) begin
              res_r <= {INS_NONE, 1'b0, 1'b1, enforce}; state_r <= S_DONE;
            end else if (row_full) begin
              res_r <= {INS_DROPPED, 3'b000}; state_r <= S_DONE;
            end else begin
              way_r <= free_way; cnt_r <= '0; lo_r <= '0; hi_r <= '0;
              hit_r <= 1'b0; state_r <= S_SRCH;
            end
          end else begin
            way_r <= way_r + WW'(1); state_r <= S_PRD;
          end
        end
        S_SRCH: begin
          mid_r <= mid;
          state_r <= (lo_r < hi_r) ? S_SCMP : S_DECIDE;
        end
        S_SCMP: begin
          if ({ld_r, li_r} == l_rdata) begin
            hit_r <= 1'b1; state_r <= S_DECIDE;
          end else begin
            if ({ld_r, li_r} < l_rdata) hi_r <= mid_r;
            else lo_r <= mid_r + CW'(1);
            state_r <= S_SRCH;
          end
        end
        S_DECIDE: begin
          k_r <= cnt_r;
          if (!ins) begin
            res_r <= {INS_NONE, hit_r, !hit_r, !hit_r && enforce}; state_r <= S_DONE;
          end else if (hit_r) begin
            res_r <= {INS_PRESENT, 3'b100}; state_r <= S_DONE;
          end else if (cnt_r >= CW'(LIBS_PER_PROGRAM)) begin
            res_r <= {INS_DROPPED, 3'b000}; state_r <= S_DONE;
          end else begin
            state_r <= S_SHRD;
          end
        end
        S_SHRD: state_r <= (k_r > lo_r) ? S_SHWR : S_FIN;
        S_SHWR: begin k_r <= km1; state_r <= S_SHRD; end
        S_FIN: begin res_r <= {INS_STORED, 3'b000}; state_r <= S_DONE; end
        S_DONE: begin
          if (!out_valid_r || out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (in_acc) begin
      op_r <= in_tuser;
      ed_r <= in_tdata[31:0];
      ei_r <= in_tdata[95:32];
      ld_r <= in_tdata[127:96];
      li_r <= in_tdata[191:128];
    end
    if (hash_done) bucket_r <= hash_bucket;
    if (state_r == S_VWT) begin
      vrow_r <= v_rdata; way_r <= '0;
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) out_res_r <= res_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  epa_hash #(.HASH_BITS(HASH_BITS)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start),
    .dev(in_tdata[31:0]), .ino(in_tdata[95:32]),
    .done(hash_done), .bucket(hash_bucket)
  );

  epa_ram #(.WIDTH(PROGRAM_WAYS), .DEPTH(ROWS)) u_valid_ram (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
  );

  epa_ram #(.WIDTH(PW), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
  );

  epa_ram #(.WIDTH(96), .DEPTH(LIB_DEPTH)) u_lib_ram (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
  );

endmodule
